### hdl/lmlt_pkg.sv
// ----------------------------------------------------------------------------
// lmlt_pkg
// Shared types and timing constants for the display mode and line timer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lmlt_pkg;

    // Display modes as reported on the result channel.
    localparam logic [1:0] MODE_HBLANK = 2'd0;
    localparam logic [1:0] MODE_VBLANK = 2'd1;
    localparam logic [1:0] MODE_OAM    = 2'd2;
    localparam logic [1:0] MODE_DRAW   = 2'd3;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_LCD_ENABLE         = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LINE_COMPARE       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HBLANK_IRQ_EN      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_VBLANK_STAT_IRQ_EN = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_OAM_IRQ_EN         = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_MATCH_IRQ_EN       = 3'd5;

    // Line timing, in clocks of the line clock.
    localparam logic [9:0] LINE_CLOCKS = 10'd456;
    localparam logic [9:0] OAM_END     = 10'd92;
    localparam logic [9:0] DRAW_END    = 10'd252;
    localparam logic [9:0] LINE_PIXELS = 10'd160;

    // Frame timing, in lines.
    localparam logic [7:0] LINES_TOTAL = 8'd154;
    localparam logic [7:0] VBLANK_LINE = 8'd144;
    localparam logic [7:0] LAST_LINE   = 8'd153;

    typedef struct packed {
        logic       lcd_enable;
        logic [7:0] line_compare;
        logic       hblank_irq_en;
        logic       vblank_stat_irq_en;
        logic       oam_irq_en;
        logic       match_irq_en;
    } lmlt_cfg_t;

    typedef struct packed {
        logic [9:0] line_clock;
        logic [1:0] mode;
        logic [7:0] line;
        logic [7:0] draw_x;
        logic       match;
    } lmlt_state_t;

    typedef struct packed {
        logic stat_irq;
        logic vblank_irq;
        logic frame_done;
    } lmlt_flags_t;

endpackage : lmlt_pkg

`default_nettype wire

### hdl/lmlt_cfg_regs.sv
// ----------------------------------------------------------------------------
// lmlt_cfg_regs
// Configuration register file: write-only, one register per defined index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lmlt_cfg_regs (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [lmlt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [lmlt_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output lmlt_pkg::lmlt_cfg_t                    cfg
);
    import lmlt_pkg::*;

    lmlt_cfg_t cfg_reg;
    lmlt_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_LCD_ENABLE:         cfg_next.lcd_enable         = cfg_wdata[0];
                REG_LINE_COMPARE:       cfg_next.line_compare       = cfg_wdata[7:0];
                REG_HBLANK_IRQ_EN:      cfg_next.hblank_irq_en      = cfg_wdata[0];
                REG_VBLANK_STAT_IRQ_EN: cfg_next.vblank_stat_irq_en = cfg_wdata[0];
                REG_OAM_IRQ_EN:         cfg_next.oam_irq_en         = cfg_wdata[0];
                REG_MATCH_IRQ_EN:       cfg_next.match_irq_en       = cfg_wdata[0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.lcd_enable         <= 1'b1;
            cfg_reg.line_compare       <= 8'd0;
            cfg_reg.hblank_irq_en      <= 1'b0;
            cfg_reg.vblank_stat_irq_en <= 1'b0;
            cfg_reg.oam_irq_en         <= 1'b0;
            cfg_reg.match_irq_en       <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule : lmlt_cfg_regs

`default_nettype wire

### hdl/lmlt_step.sv
// ----------------------------------------------------------------------------
// lmlt_step
// Next-state logic: advances the line clock by one timing update and makes
// at most one mode change.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lmlt_step (
    input  wire lmlt_pkg::lmlt_cfg_t   cfg,
    input  wire lmlt_pkg::lmlt_state_t st,
    input  wire logic [5:0]            clocks,
    output lmlt_pkg::lmlt_state_t      st_next,
    output lmlt_pkg::lmlt_flags_t      flags
);
    import lmlt_pkg::*;

    logic [9:0] clk_sum;
    logic [9:0] target;
    logic [7:0] capped;
    logic [7:0] line_inc;
    logic [7:0] new_line;
    logic       hit;

    always_comb begin
        clk_sum  = st.line_clock + {4'd0, clocks};
        target   = clk_sum - (OAM_END - 10'd1);
        capped   = (target > LINE_PIXELS) ? LINE_PIXELS[7:0] : target[7:0];
        line_inc = st.line + 8'd1;
        new_line = (line_inc == LINES_TOTAL) ? 8'd0 : line_inc;
        // A compare value of zero stands for the last line of the frame.
        hit      = (cfg.line_compare != 8'd0) ? (new_line == cfg.line_compare)
                                              : (new_line == LAST_LINE);

        st_next = st;
        flags   = '0;

        if (cfg.lcd_enable) begin
            st_next.line_clock = clk_sum;
            case (st.mode)
                MODE_OAM: begin
                    st_next.draw_x = 8'd0;
                    if (clk_sum >= OAM_END) begin
                        st_next.mode = MODE_DRAW;
                    end
                end
                MODE_DRAW: begin
                    if (clk_sum >= OAM_END && capped > st.draw_x) begin
                        st_next.draw_x = capped;
                    end
                    if (clk_sum >= DRAW_END) begin
                        st_next.mode   = MODE_HBLANK;
                        flags.stat_irq = cfg.hblank_irq_en;
                    end
                end
                default: begin
                    if (clk_sum >= LINE_CLOCKS) begin
                        st_next.line_clock = clk_sum - LINE_CLOCKS;
                        st_next.line       = new_line;
                        flags.frame_done   = (line_inc == LINES_TOTAL);
                        if (new_line == VBLANK_LINE) begin
                            st_next.mode     = MODE_VBLANK;
                            flags.vblank_irq = 1'b1;
                            flags.stat_irq   = cfg.vblank_stat_irq_en | cfg.oam_irq_en;
                        end else if (new_line < VBLANK_LINE) begin
                            st_next.mode   = MODE_OAM;
                            flags.stat_irq = cfg.oam_irq_en;
                        end
                        // Only a newly set match raises the interrupt.
                        if (hit) begin
                            st_next.match = 1'b1;
                            if (!st.match && cfg.match_irq_en) begin
                                flags.stat_irq = 1'b1;
                            end
                        end else begin
                            st_next.match = 1'b0;
                        end
                    end
                end
            endcase
        end
    end

endmodule : lmlt_step

`default_nettype wire

### hdl/lcd_mode_line_timer.sv
// ----------------------------------------------------------------------------
// lcd_mode_line_timer
// Line and mode timing of a display controller with interrupt generation.
// ----------------------------------------------------------------------------
// Each input transaction carries the number of clocks elapsed since the last
// one; each produces exactly one result transaction with the mode, line, draw
// position, match flag and the interrupts raised by that update. The block
// takes one transaction per clock while the result side does not stall: a
// transaction is held in an input register, then the timing state and the
// result register are updated from it once the result register is free or
// being read. The combinational state update is what sets this rate.
// Configuration is write-only and should change only while no transaction is
// in flight.
`timescale 1ns / 1ps
`default_nettype none

module lcd_mode_line_timer (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [lmlt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [lmlt_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                              s_valid,
    output      logic                              s_ready,
    input  wire logic [5:0]                        s_clocks,
    output      logic                              m_valid,
    input  wire logic                              m_ready,
    output      logic [1:0]                        m_mode,
    output      logic [7:0]                        m_line,
    output      logic [7:0]                        m_pixels_drawn,
    output      logic                              m_match_flag,
    output      logic                              m_stat_irq,
    output      logic                              m_vblank_irq,
    output      logic                              m_frame_done
);
    import lmlt_pkg::*;

    lmlt_cfg_t   cfg;
    lmlt_state_t state_reg;
    lmlt_state_t state_next;
    lmlt_flags_t flags;

    logic        in_valid_reg;
    logic [5:0]  clocks_reg;
    logic        out_valid_reg;
    lmlt_flags_t flags_reg;
    logic        advance;

    lmlt_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    lmlt_step u_step (
        .cfg     (cfg),
        .st      (state_reg),
        .clocks  (clocks_reg),
        .st_next (state_next),
        .flags   (flags)
    );

    // The held transaction moves on whenever the result register is free.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
            state_reg.line_clock  <= 10'd0;
            state_reg.mode        <= MODE_OAM;
            state_reg.line        <= 8'd0;
            state_reg.draw_x      <= 8'd0;
            state_reg.match       <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            clocks_reg <= s_clocks;
        end
        if (advance) begin
            flags_reg <= flags;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_mode         = state_reg.mode;
    assign m_line         = state_reg.line;
    assign m_pixels_drawn = state_reg.draw_x;
    assign m_match_flag   = state_reg.match;
    assign m_stat_irq     = flags_reg.stat_irq;
    assign m_vblank_irq   = flags_reg.vblank_irq;
    assign m_frame_done   = flags_reg.frame_done;

    // The draw position is capped at one line of pixels.
    a_draw_cap : assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.draw_x <= LINE_PIXELS[7:0])
        else $error("draw position beyond line width");

    // A wrapped frame always lands on the first line.
    a_frame_wrap : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_done |-> m_line == 8'd0)
        else $error("frame wrap without line zero");

    // The v-blank interrupt comes only with entry into v-blank on its first line.
    a_vblank_entry : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_vblank_irq |-> m_mode == MODE_VBLANK && m_line == VBLANK_LINE)
        else $error("v-blank interrupt outside v-blank entry");

    // With the display off, a processed transaction leaves the timing untouched.
    a_frozen : assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !cfg.lcd_enable |=> $stable(state_reg) && flags_reg == '0)
        else $error("timing changed while display disabled");

endmodule : lcd_mode_line_timer

`default_nettype wire

### verif/lmlt_timing_monitor.sv
// ----------------------------------------------------------------------------
// lmlt_timing_monitor
// Predicts the display timing results and compares them with the result port.
// ----------------------------------------------------------------------------
// Tracks the register writes and every accepted input transaction. Each one
// advances a private copy of the line clock, mode, line, draw position and
// match flag. Result transactions are checked field by field, in order.
`timescale 1ns / 1ps

module lmlt_timing_monitor (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire logic [lmlt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [lmlt_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                             s_valid,
    input  wire logic                             s_ready,
    input  wire logic [5:0]                       s_clocks,
    input  wire logic                             m_valid,
    input  wire logic                             m_ready,
    input  wire logic [1:0]                       m_mode,
    input  wire logic [7:0]                       m_line,
    input  wire logic [7:0]                       m_pixels_drawn,
    input  wire logic                             m_match_flag,
    input  wire logic                             m_stat_irq,
    input  wire logic                             m_vblank_irq,
    input  wire logic                             m_frame_done,
    output int unsigned                           fail_count,
    output int unsigned                           pending
);
    import lmlt_pkg::*;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  line;
        logic [7:0]  pixels;
        logic        match;
        lmlt_flags_t flags;
    } line_status_t;

    lmlt_cfg_t    cfg;
    lmlt_state_t  timing;
    line_status_t line_status_q[$];

    // Advances the timing state by the given number of clocks. At most one
    // mode change happens per transaction.
    function automatic line_status_t advance_timing(input logic [5:0] clks);
        line_status_t res;
        logic [9:0]   target;
        logic         hit;
        res = '0;
        if (cfg.lcd_enable) begin
            timing.line_clock = timing.line_clock + 10'(clks);
            case (timing.mode)
                MODE_OAM: begin
                    timing.draw_x = '0;
                    if (timing.line_clock >= OAM_END) timing.mode = MODE_DRAW;
                end
                MODE_DRAW: begin
                    if (timing.line_clock >= OAM_END) begin
                        target = timing.line_clock - OAM_END + 10'd1;
                        if (target > LINE_PIXELS) target = LINE_PIXELS;
                        if (target > {2'b00, timing.draw_x}) timing.draw_x = target[7:0];
                    end
                    if (timing.line_clock >= DRAW_END) begin
                        timing.mode = MODE_HBLANK;
                        if (cfg.hblank_irq_en) res.flags.stat_irq = 1'b1;
                    end
                end
                default: begin
                    if (timing.line_clock >= LINE_CLOCKS) begin
                        timing.line_clock = timing.line_clock - LINE_CLOCKS;
                        timing.line = timing.line + 8'd1;
                        if (timing.line == LINES_TOTAL) begin
                            timing.line = '0;
                            res.flags.frame_done = 1'b1;
                        end
                        if (timing.line == VBLANK_LINE) begin
                            timing.mode = MODE_VBLANK;
                            res.flags.vblank_irq = 1'b1;
                            if (cfg.vblank_stat_irq_en || cfg.oam_irq_en)
                                res.flags.stat_irq = 1'b1;
                        end else if (timing.line < VBLANK_LINE) begin
                            timing.mode = MODE_OAM;
                            if (cfg.oam_irq_en) res.flags.stat_irq = 1'b1;
                        end
                        // A compare value of zero stands for the last line.
                        hit = (cfg.line_compare != 8'd0) ? (timing.line == cfg.line_compare)
                                                         : (timing.line == LAST_LINE);
                        if (!hit) begin
                            timing.match = 1'b0;
                        end else if (!timing.match) begin
                            timing.match = 1'b1;
                            if (cfg.match_irq_en) res.flags.stat_irq = 1'b1;
                        end
                    end
                end
            endcase
        end
        res.mode   = timing.mode;
        res.line   = timing.line;
        res.pixels = timing.draw_x;
        res.match  = timing.match;
        return res;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        line_status_t want;
        if (!aresetn) begin
            cfg = '0;
            cfg.lcd_enable = 1'b1;
            timing = '0;
            timing.mode = MODE_OAM;
            line_status_q.delete();
            fail_count = 0;
            pending = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_LCD_ENABLE:         cfg.lcd_enable = cfg_wdata[0];
                    REG_LINE_COMPARE:       cfg.line_compare = cfg_wdata[7:0];
                    REG_HBLANK_IRQ_EN:      cfg.hblank_irq_en = cfg_wdata[0];
                    REG_VBLANK_STAT_IRQ_EN: cfg.vblank_stat_irq_en = cfg_wdata[0];
                    REG_OAM_IRQ_EN:         cfg.oam_irq_en = cfg_wdata[0];
                    REG_MATCH_IRQ_EN:       cfg.match_irq_en = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (line_status_q.size() == 0) begin
                    $error("result transaction with no timing update outstanding");
                    fail_count++;
                end else begin
                    want = line_status_q.pop_front();
                    check_field("mode", want.mode, m_mode);
                    check_field("line", want.line, m_line);
                    check_field("pixels_drawn", want.pixels, m_pixels_drawn);
                    check_field("match_flag", want.match, m_match_flag);
                    check_field("stat_irq", want.flags.stat_irq, m_stat_irq);
                    check_field("vblank_irq", want.flags.vblank_irq, m_vblank_irq);
                    check_field("frame_done", want.flags.frame_done, m_frame_done);
                end
            end
            if (s_valid && s_ready) line_status_q.push_back(advance_timing(s_clocks));
            pending = line_status_q.size();
        end
    end

endmodule : lmlt_timing_monitor

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the display mode and line timer.
// ----------------------------------------------------------------------------
// A short directed sequence covers the clock count extremes, a disabled
// display and all interrupt enables. Random phases follow, each started from
// an idle block with a fresh register setting, with random gaps on both
// channels and one long stall of the result side.
`timescale 1ns / 1ps

module tb_top;
    import lmlt_pkg::*;

    localparam int unsigned RANDOM_ITEMS  = 1900;
    localparam int unsigned CYCLE_LIMIT   = 2000000;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned SETTLE_CYCLES = 8;
    // Indexes past the register list; writes to them must have no effect.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_valid;
    logic                   s_ready;
    logic [5:0]             s_clocks;
    logic                   m_valid;
    logic                   m_ready;
    logic [1:0]             m_mode;
    logic [7:0]             m_line;
    logic [7:0]             m_pixels_drawn;
    logic                   m_match_flag;
    logic                   m_stat_irq;
    logic                   m_vblank_irq;
    logic                   m_frame_done;
    int unsigned            fail_count;
    int unsigned            pending;

    bit                     send_calm = 1'b0;
    bit                     recv_calm = 1'b0;
    bit                     hold_req  = 1'b0;
    logic [7:0]             last_line = '0;
    int unsigned            cycle_count = 0;

    lcd_mode_line_timer u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_clocks       (s_clocks),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_mode         (m_mode),
        .m_line         (m_line),
        .m_pixels_drawn (m_pixels_drawn),
        .m_match_flag   (m_match_flag),
        .m_stat_irq     (m_stat_irq),
        .m_vblank_irq   (m_vblank_irq),
        .m_frame_done   (m_frame_done)
    );

    lmlt_timing_monitor u_timing_monitor (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_clocks       (s_clocks),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_mode         (m_mode),
        .m_line         (m_line),
        .m_pixels_drawn (m_pixels_drawn),
        .m_match_flag   (m_match_flag),
        .m_stat_irq     (m_stat_irq),
        .m_vblank_irq   (m_vblank_irq),
        .m_frame_done   (m_frame_done),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // The last line seen steers the compare value toward lines coming soon.
    always @(posedge aclk) begin
        if (m_valid && m_ready) last_line <= m_line;
    end

    function automatic int unsigned pick_gap(input bit calm);
        int unsigned r;
        r = $urandom_range(99);
        if (calm || r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Mostly large counts so that the run covers the v-blank lines and a wrap.
    function automatic logic [5:0] pick_clocks();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 85) return 6'($urandom_range(52, 63));
        if (r < 96) return 6'($urandom_range(63));
        return 6'($urandom_range(3));
    endfunction

    function automatic logic [7:0] pick_compare();
        int unsigned r;
        int unsigned v;
        r = $urandom_range(99);
        if (r < 45) begin
            v = last_line + $urandom_range(1, 10);
            if (v > LAST_LINE) v = v - LINES_TOTAL;
            return 8'(v);
        end
        if (r < 60) return 8'd0;
        if (r < 70) return 8'd255;
        return 8'($urandom_range(255));
    endfunction

    task automatic push_timing(input logic [5:0] clk_cnt);
        int unsigned gap;
        gap = pick_gap(send_calm);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid  = 1'b1;
        s_clocks = clk_cnt;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(negedge aclk);
        cfg_we    = 1'b0;
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Result side: random stalls, plus one long hold-off when requested.
    initial begin
        int unsigned gap;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready  = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            gap = pick_gap(recv_calm);
            if (gap == 0) begin
                m_ready = 1'b1;
            end else begin
                m_ready = 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
    end

    initial begin
        int unsigned sent;
        int unsigned phase;
        int unsigned phase_len;
        bit          lit;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_clocks  = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Reset setting: clock count extremes and each single bit.
        push_timing(6'd0);
        push_timing(6'd63);
        for (int b = 0; b < 6; b++) push_timing(6'(1 << b));

        // Display off, written with junk in the upper bits: timing must freeze.
        wait_idle();
        write_reg(REG_LCD_ENABLE, 8'hFE);
        push_timing(6'd63);
        push_timing(6'd42);
        push_timing(6'd21);

        // Every interrupt enabled, compare on line 1, across a line boundary.
        wait_idle();
        write_reg(REG_LCD_ENABLE, 8'h01);
        write_reg(REG_LINE_COMPARE, 8'd1);
        write_reg(REG_HBLANK_IRQ_EN, 8'h01);
        write_reg(REG_VBLANK_STAT_IRQ_EN, 8'h81);
        write_reg(REG_OAM_IRQ_EN, 8'h01);
        write_reg(REG_MATCH_IRQ_EN, 8'h01);
        write_reg(REG_SPARE_LO, 8'hFF);
        write_reg(REG_SPARE_HI, 8'h00);
        repeat (14) push_timing(6'd63);

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            wait_idle();
            lit = ($urandom_range(9) != 0) || (phase == 2);
            write_reg(REG_LCD_ENABLE, {7'($urandom), lit});
            write_reg(REG_LINE_COMPARE, pick_compare());
            write_reg(REG_HBLANK_IRQ_EN, 8'($urandom));
            write_reg(REG_VBLANK_STAT_IRQ_EN, 8'($urandom));
            write_reg(REG_OAM_IRQ_EN, 8'($urandom));
            write_reg(REG_MATCH_IRQ_EN, 8'($urandom));
            if ($urandom_range(3) == 0)
                write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, 8'($urandom));
            send_calm = ($urandom_range(4) == 0);
            recv_calm = ($urandom_range(4) == 0);
            // One phase keeps offering transactions into a long output stall.
            if (phase == 2) begin
                send_calm = 1'b1;
                hold_req  = 1'b1;
            end
            phase_len = lit ? $urandom_range(60, 250) : $urandom_range(8, 24);
            repeat (phase_len) push_timing(pick_clocks());
            if (lit) sent += phase_len;
            phase++;
        end

        wait_idle();
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule : tb_top

### filelist.f
hdl/lmlt_pkg.sv
hdl/lmlt_cfg_regs.sv
hdl/lmlt_step.sv
hdl/lcd_mode_line_timer.sv
verif/lmlt_timing_monitor.sv
verif/tb_top.sv
